@@ rtl/ptst_pkg.sv @@
package ptst_pkg;

  // defaults for the top level parameters
  localparam int SLOTS_DEF     = 8;
  localparam int TICK_RATE_DEF = 32768;

  // fixed field widths
  localparam int KEY_W  = 8;
  localparam int PER_W  = 16;
  localparam int RPT_W  = 16;
  localparam int TICK_W = 24;
  localparam int SLOT_W = 3;

  // threshold (period + 1) * tick rate, largest is 2^16 * 2^15
  localparam int THR_W = 32;
  // elapsed ticks times ms per second
  localparam int MS_PER_S = 1000;
  localparam int ELW      = TICK_W + 10;

  // firings reported by one tick
  localparam int MAX_RESULTS = 8;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NOP  = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // one timer slot as it travels along the ring of cells
  typedef struct packed {
    logic                    used;
    logic [KEY_W-1:0]        key;
    logic [TICK_W-1:0]       start;
    logic [THR_W-1:0]        thr;
    logic signed [RPT_W-1:0] rpt;
    logic [RPT_W-1:0]        cnt;
  } slot_t;

  // request context seen by the head of the ring
  typedef struct packed {
    req_kind_t               kind;
    logic [KEY_W-1:0]        key;
    logic [TICK_W-1:0]       now;
    logic [THR_W-1:0]        thr;
    logic signed [RPT_W-1:0] rpt;
    logic                    add_free;
    logic                    fire_ok;
  } req_ctx_t;

  // what the head did with the slot
  typedef struct packed {
    logic fire;
    logic took;
  } head_res_t;

endpackage

@@ rtl/ptst_cell.sv @@
module ptst_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  ptst_pkg::slot_t slot_in,
  output ptst_pkg::slot_t slot_out
);

  ptst_pkg::slot_t slot_r;

  // only the used flag needs a reset, the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.used <= 1'b0;
    end else if (shift_en) begin
      slot_r <= slot_in;
    end
  end

  assign slot_out = slot_r;

endmodule

@@ rtl/ptst_head.sv @@
module ptst_head (
  input  ptst_pkg::slot_t     slot_in,
  input  ptst_pkg::req_ctx_t  ctx,
  output ptst_pkg::slot_t     slot_out,
  output ptst_pkg::head_res_t res
);

  logic [ptst_pkg::TICK_W-1:0] elapsed;
  logic [ptst_pkg::ELW-1:0]    scaled;
  logic                        expired;

  assign elapsed = ctx.now - slot_in.start;
  assign scaled  = ptst_pkg::ELW'(elapsed) * ptst_pkg::ELW'(ptst_pkg::MS_PER_S);
  // floor(elapsed * 1000 / rate) > period  <=>  elapsed * 1000 >= (period + 1) * rate
  assign expired = scaled >= ptst_pkg::ELW'(slot_in.thr);

  always_comb begin
    slot_out  = slot_in;
    res.fire  = 1'b0;
    res.took  = 1'b0;
    case (ctx.kind)
      ptst_pkg::REQ_ADD: begin
        if (!slot_in.used && ctx.add_free) begin
          slot_out.used  = 1'b1;
          slot_out.key   = ctx.key;
          slot_out.start = '0;
          slot_out.thr   = ctx.thr;
          slot_out.rpt   = ctx.rpt;
          slot_out.cnt   = '0;
          res.took       = 1'b1;
        end
      end
      ptst_pkg::REQ_DEL: begin
        if (slot_in.used && ctx.key != '0 && slot_in.key == ctx.key) begin
          slot_out = '0;
        end
      end
      ptst_pkg::REQ_TICK: begin
        if (slot_in.used && ctx.fire_ok && expired) begin
          slot_out.start = ctx.now;
          if (slot_in.rpt < 0) begin
            res.fire = 1'b1;
          end else if (ptst_pkg::RPT_W'(slot_in.rpt) > slot_in.cnt) begin
            res.fire     = 1'b1;
            slot_out.cnt = slot_in.cnt + 1'b1;
          end else begin
            slot_out.used = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/periodic_timer_slot_table_unit.sv @@
// periodic timer slot table
//
// in_*  : one request transaction per item: add (key, period in ms, repeat
//         count, negative repeats forever), delete by key, or tick with the
//         current 24-bit counter value. in_stall is low only while idle.
// out_* : result transactions. add and delete give one result carrying the
//         status. a tick gives one result per firing slot in slot order,
//         or a single result with fired low; out_last marks the final one.
// the slots live in a ring of SLOTS cells that rotates one place a cycle
// during a scan while the output is free; the cell at the head of the ring
// is examined and updated as it passes. a request is taken while idle, then
// the scan brings each of the SLOTS slots past the head once, and a closing
// step registers the closing result; the next request is taken only after
// that, so a new request is never taken while one is still in progress.
// a firing is held until the next firing or the closing cycle, and only then
// enters the output register, after its slot has passed the head.
// a stalled output holds the rotation (one firing is kept pending so that
// the last flag is known before it leaves) and with it the whole block.
// reset empties the table at once: only the used flags are cleared.
// a tick reports at most eight firings; later slots wait for the next tick.
module periodic_timer_slot_table_unit #(
  parameter int SLOTS     = ptst_pkg::SLOTS_DEF,
  parameter int TICK_RATE = ptst_pkg::TICK_RATE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [ptst_pkg::KEY_W-1:0]         in_timer_key,
  input  logic [ptst_pkg::PER_W-1:0]         in_period_ms,
  input  logic signed [ptst_pkg::RPT_W-1:0]  in_repeat_count,
  input  logic [ptst_pkg::TICK_W-1:0]        in_now_tick,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_fired,
  output logic [ptst_pkg::KEY_W-1:0]         out_fired_key,
  output logic [ptst_pkg::SLOT_W-1:0]        out_fired_slot,
  output logic                               out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                          state_r;
  logic [IDX_W-1:0]                step_r;
  logic [ptst_pkg::NCNT_W-1:0]     nfire_r;
  logic                            took_r;
  logic                            reject_r;
  ptst_pkg::req_kind_t             kind_r;
  logic [ptst_pkg::KEY_W-1:0]      key_r;
  logic [ptst_pkg::TICK_W-1:0]     now_r;
  logic [ptst_pkg::THR_W-1:0]      thr_r;
  logic signed [ptst_pkg::RPT_W-1:0] rpt_r;

  // firing held back until the next one or the end of the scan
  logic                            pend_v_r;
  logic [ptst_pkg::KEY_W-1:0]      pend_key_r;
  logic [ptst_pkg::SLOT_W-1:0]     pend_slot_r;

  // output register
  logic                            out_valid_r;
  ptst_pkg::status_t               out_status_r;
  logic                            out_fired_r;
  logic [ptst_pkg::KEY_W-1:0]      out_key_r;
  logic [ptst_pkg::SLOT_W-1:0]     out_slot_r;
  logic                            out_last_r;

  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic                            step_en;
  ptst_pkg::req_ctx_t              ctx;
  ptst_pkg::head_res_t             hres;
  ptst_pkg::slot_t                 head_new;
  ptst_pkg::slot_t                 ring_q [SLOTS];
  ptst_pkg::slot_t                 ring_d [SLOTS];
  ptst_pkg::req_kind_t             in_kind;
  logic                            in_reject;
  ptst_pkg::status_t               fin_status;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // the output register can take a new transaction this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = (state_r == S_SCAN) && out_free;
  // a new transaction enters the output register this cycle
  assign out_load = (step_en && hres.fire && pend_v_r) ||
                    ((state_r == S_FINISH) && out_free);

  assign in_kind   = ptst_pkg::req_kind_t'(in_req_type);
  assign in_reject = (in_kind == ptst_pkg::REQ_ADD) &&
                     (in_timer_key == '0 || in_period_ms == '0);

  // ring of slot cells, head is cell 0, the updated head re-enters at the tail
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_ring
      if (gi == SLOTS - 1) begin : g_tail
        assign ring_d[gi] = head_new;
      end else begin : g_mid
        assign ring_d[gi] = ring_q[gi+1];
      end
      ptst_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (step_en),
        .slot_in  (ring_d[gi]),
        .slot_out (ring_q[gi])
      );
    end
  endgenerate

  always_comb begin
    ctx.kind     = kind_r;
    ctx.key      = key_r;
    ctx.now      = now_r;
    ctx.thr      = thr_r;
    ctx.rpt      = rpt_r;
    ctx.add_free = !took_r;
    ctx.fire_ok  = (nfire_r < ptst_pkg::NCNT_W'(ptst_pkg::MAX_RESULTS));
  end

  ptst_head u_head (
    .slot_in  (ring_q[0]),
    .ctx      (ctx),
    .slot_out (head_new),
    .res      (hres)
  );

  // status of the closing result
  always_comb begin
    fin_status = ptst_pkg::ST_OK;
    if (kind_r == ptst_pkg::REQ_ADD) begin
      fin_status = took_r ? ptst_pkg::ST_OK : ptst_pkg::ST_FULL;
    end
    if (reject_r) begin
      fin_status = ptst_pkg::ST_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      nfire_r     <= '0;
      took_r      <= 1'b0;
      reject_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            // a rejected add walks the ring without touching it
            kind_r   <= in_reject ? ptst_pkg::REQ_NOP : in_kind;
            reject_r <= in_reject;
            key_r    <= in_timer_key;
            now_r    <= in_now_tick;
            rpt_r    <= in_repeat_count;
            thr_r    <= ptst_pkg::THR_W'((33'(in_period_ms) + 33'd1) * 33'(TICK_RATE));
            step_r   <= '0;
            nfire_r  <= '0;
            took_r   <= 1'b0;
            pend_v_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step_en) begin
            if (hres.took) begin
              took_r <= 1'b1;
            end
            if (hres.fire) begin
              nfire_r     <= nfire_r + 1'b1;
              pend_v_r    <= 1'b1;
              pend_key_r  <= ring_q[0].key;
              pend_slot_r <= ptst_pkg::SLOT_W'(step_r);
              if (pend_v_r) begin
                out_status_r <= ptst_pkg::ST_OK;
                out_fired_r  <= 1'b1;
                out_key_r    <= pend_key_r;
                out_slot_r   <= pend_slot_r;
                out_last_r   <= 1'b0;
              end
            end
            if (step_r == IDX_W'(SLOTS - 1)) begin
              state_r <= S_FINISH;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            if (pend_v_r) begin
              out_status_r <= ptst_pkg::ST_OK;
              out_fired_r  <= 1'b1;
              out_key_r    <= pend_key_r;
              out_slot_r   <= pend_slot_r;
            end else begin
              out_status_r <= fin_status;
              out_fired_r  <= 1'b0;
              out_key_r    <= '0;
              out_slot_r   <= '0;
            end
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fired      = out_fired_r;
  assign out_fired_key  = out_key_r;
  assign out_fired_slot = out_slot_r;
  assign out_last       = out_last_r;

  // a tick never reports more firings than allowed
  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfire_r <= ptst_pkg::NCNT_W'(ptst_pkg::MAX_RESULTS))
    else $error("firing count above limit");

  // an accepted request always starts a ring scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SCAN)
    else $error("accepted request did not start a scan");

  // no firing is left pending once the block is idle
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> state_r != S_IDLE)
    else $error("pending firing while idle");

  // a result without a firing is always the closing one
  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_fired_r) |-> out_last_r)
    else $error("non-firing result not marked last");

  // the ring only rotates while scanning
  a_rot_scan: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> (state_r == S_SCAN && out_free))
    else $error("ring moved outside a scan");

endmodule
